### design/cdes_pkg.sv
// Shared types and constants for the civil date to epoch seconds converter.
// No dependencies; used by the stream interface instances and the top level.
package cdes_pkg;

    typedef struct packed {
        logic        time_valid;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day_of_month;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
    } date_time_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        date_accepted;
    } epoch_t;

    localparam logic [15:0] EPOCH_YEAR      = 16'd1970;
    localparam logic [15:0] MIN_YEAR        = 16'd1980;
    localparam logic [7:0]  MAX_MONTH       = 8'd12;
    localparam logic [7:0]  MAX_DAY         = 8'd31;
    localparam logic [7:0]  MAX_HOUR        = 8'd23;
    localparam logic [7:0]  MAX_MINUTE      = 8'd59;
    localparam logic [7:0]  MAX_SECOND      = 8'd60;

    localparam logic [24:0] DAYS_PER_YEAR   = 25'd365;
    localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
    localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN    = 17'd60;

    // floor(n / 100) == (n * 83887) >> 23 for any 16-bit n
    localparam logic [32:0] RECIP_100       = 33'd83887;
    localparam int          RECIP_100_SHIFT = 23;
    localparam logic [16:0] CENTURY         = 17'd100;

    // leap years in 1..1969
    localparam logic [15:0] LEAPS_BEFORE_EPOCH = 16'd477;

    function automatic logic [8:0] days_before_month(input logic leap, input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

### design/cdes_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is set per instance, normally a struct from cdes_pkg.
interface cdes_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

### design/civil_date_to_epoch_seconds_top.sv
// Converts a UTC calendar date and time to Unix epoch seconds, modulo 2^32.
// Depends on cdes_pkg and cdes_stream_if.
//
// One transaction on date_time gives one transaction on epoch. The datapath is
// a five-stage pipeline (validate and reciprocal multiply for the century
// counts, leap count and year days, day total and time of day, days times
// 86400, final add into the output register), and a new input is taken every
// cycle while epoch is ready. The pipeline advances as a whole: when the output
// register holds a result that is not taken, every stage holds and
// date_time.ready is low. Rejected inputs (invalid flag, year before 1980 or a
// field out of range) give epoch_seconds 0 with date_accepted 0. Day is not
// checked against month length.
module civil_date_to_epoch_seconds_top (
    input  logic          clk,
    input  logic          rst_n,
    cdes_stream_if.sink   date_time,
    cdes_stream_if.source epoch
);

    logic advance;

    // stage 1: validation, century reciprocal products
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_ok_reg, s1_ok_next;
    logic [15:0] s1_year_reg, s1_year_next;
    logic [15:0] s1_ym1_reg, s1_ym1_next;
    logic [32:0] s1_py_reg, s1_py_next;
    logic [32:0] s1_pym1_reg, s1_pym1_next;
    logic [3:0]  s1_midx_reg, s1_midx_next;
    logic [4:0]  s1_day_reg, s1_day_next;
    logic [4:0]  s1_hour_reg, s1_hour_next;
    logic [5:0]  s1_min_reg, s1_min_next;
    logic [5:0]  s1_sec_reg, s1_sec_next;

    // stage 2: leap flag, leap count, days of whole years
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_ok_reg, s2_ok_next;
    logic        s2_leap_reg, s2_leap_next;
    logic [13:0] s2_leaps_reg, s2_leaps_next;
    logic [24:0] s2_dy_reg, s2_dy_next;
    logic [3:0]  s2_midx_reg, s2_midx_next;
    logic [4:0]  s2_day_reg, s2_day_next;
    logic [4:0]  s2_hour_reg, s2_hour_next;
    logic [5:0]  s2_min_reg, s2_min_next;
    logic [5:0]  s2_sec_reg, s2_sec_next;

    // stage 3: total days, seconds of day
    logic        s3_valid_reg, s3_valid_next;
    logic        s3_ok_reg, s3_ok_next;
    logic [24:0] s3_days_reg, s3_days_next;
    logic [16:0] s3_hms_reg, s3_hms_next;

    // stage 4: days scaled to seconds
    logic        s4_valid_reg, s4_valid_next;
    logic        s4_ok_reg, s4_ok_next;
    logic [31:0] s4_prod_reg, s4_prod_next;
    logic [16:0] s4_hms_reg, s4_hms_next;

    // stage 5: output register
    logic        s5_valid_reg, s5_valid_next;
    logic        s5_ok_reg, s5_ok_next;
    logic [31:0] s5_secs_reg, s5_secs_next;

    logic [9:0]  q100_y;
    logic [9:0]  q100_ym1;
    logic [16:0] century_y;
    logic [15:0] leaps_wide;
    logic [15:0] years_since;
    logic [8:0]  dbm;
    logic [31:0] total;

    assign advance         = !s5_valid_reg || epoch.ready;
    assign date_time.ready = advance;

    always_comb
    begin
        s1_valid_next = date_time.valid;
        s1_ok_next    = date_time.payload.time_valid
                     && (date_time.payload.year >= cdes_pkg::MIN_YEAR)
                     && (date_time.payload.month >= 8'd1)
                     && (date_time.payload.month <= cdes_pkg::MAX_MONTH)
                     && (date_time.payload.day_of_month >= 8'd1)
                     && (date_time.payload.day_of_month <= cdes_pkg::MAX_DAY)
                     && (date_time.payload.hour <= cdes_pkg::MAX_HOUR)
                     && (date_time.payload.minute <= cdes_pkg::MAX_MINUTE)
                     && (date_time.payload.second <= cdes_pkg::MAX_SECOND);
        s1_year_next  = date_time.payload.year;
        s1_ym1_next   = date_time.payload.year - 16'd1;
        s1_py_next    = {17'd0, date_time.payload.year} * cdes_pkg::RECIP_100;
        s1_pym1_next  = {17'd0, s1_ym1_next} * cdes_pkg::RECIP_100;
        s1_midx_next  = date_time.payload.month[3:0] - 4'd1;
        s1_day_next   = date_time.payload.day_of_month[4:0];
        s1_hour_next  = date_time.payload.hour[4:0];
        s1_min_next   = date_time.payload.minute[5:0];
        s1_sec_next   = date_time.payload.second[5:0];
    end

    always_comb
    begin
        q100_y      = s1_py_reg[cdes_pkg::RECIP_100_SHIFT +: 10];
        q100_ym1    = s1_pym1_reg[cdes_pkg::RECIP_100_SHIFT +: 10];
        century_y   = {7'd0, q100_y} * cdes_pkg::CENTURY;
        // leaps(y-1) - leaps(1969): n/4 - n/100 + n/400 with n = y-1 and n/400 = (n/100)/4
        leaps_wide  = {2'd0, s1_ym1_reg[15:2]} - {6'd0, q100_ym1}
                    + {8'd0, q100_ym1[9:2]} - cdes_pkg::LEAPS_BEFORE_EPOCH;
        years_since = s1_year_reg - cdes_pkg::EPOCH_YEAR;

        s2_valid_next = s1_valid_reg;
        s2_ok_next    = s1_ok_reg;
        s2_leap_next  = (s1_year_reg[1:0] == 2'd0)
                     && (({1'b0, s1_year_reg} != century_y) || (q100_y[1:0] == 2'd0));
        s2_leaps_next = leaps_wide[13:0];
        s2_dy_next    = {9'd0, years_since} * cdes_pkg::DAYS_PER_YEAR;
        s2_midx_next  = s1_midx_reg;
        s2_day_next   = s1_day_reg;
        s2_hour_next  = s1_hour_reg;
        s2_min_next   = s1_min_reg;
        s2_sec_next   = s1_sec_reg;
    end

    always_comb
    begin
        dbm           = cdes_pkg::days_before_month(s2_leap_reg, s2_midx_reg);
        s3_valid_next = s2_valid_reg;
        s3_ok_next    = s2_ok_reg;
        s3_days_next  = s2_dy_reg + {11'd0, s2_leaps_reg} + {16'd0, dbm}
                      + {20'd0, s2_day_reg - 5'd1};
        s3_hms_next   = {12'd0, s2_hour_reg} * cdes_pkg::SECS_PER_HOUR
                      + {11'd0, s2_min_reg} * cdes_pkg::SECS_PER_MIN
                      + {11'd0, s2_sec_reg};
    end

    always_comb
    begin
        s4_valid_next = s3_valid_reg;
        s4_ok_next    = s3_ok_reg;
        s4_prod_next  = {7'd0, s3_days_reg} * cdes_pkg::SECS_PER_DAY;
        s4_hms_next   = s3_hms_reg;
    end

    always_comb
    begin
        total         = s4_prod_reg + {15'd0, s4_hms_reg};
        s5_valid_next = s4_valid_reg;
        s5_ok_next    = s4_ok_reg;
        s5_secs_next  = s4_ok_reg ? total : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ok_reg    <= s1_ok_next;
            s1_year_reg  <= s1_year_next;
            s1_ym1_reg   <= s1_ym1_next;
            s1_py_reg    <= s1_py_next;
            s1_pym1_reg  <= s1_pym1_next;
            s1_midx_reg  <= s1_midx_next;
            s1_day_reg   <= s1_day_next;
            s1_hour_reg  <= s1_hour_next;
            s1_min_reg   <= s1_min_next;
            s1_sec_reg   <= s1_sec_next;

            s2_ok_reg    <= s2_ok_next;
            s2_leap_reg  <= s2_leap_next;
            s2_leaps_reg <= s2_leaps_next;
            s2_dy_reg    <= s2_dy_next;
            s2_midx_reg  <= s2_midx_next;
            s2_day_reg   <= s2_day_next;
            s2_hour_reg  <= s2_hour_next;
            s2_min_reg   <= s2_min_next;
            s2_sec_reg   <= s2_sec_next;

            s3_ok_reg    <= s3_ok_next;
            s3_days_reg  <= s3_days_next;
            s3_hms_reg   <= s3_hms_next;

            s4_ok_reg    <= s4_ok_next;
            s4_prod_reg  <= s4_prod_next;
            s4_hms_reg   <= s4_hms_next;

            s5_ok_reg    <= s5_ok_next;
            s5_secs_reg  <= s5_secs_next;
        end
    end

    assign epoch.valid                 = s5_valid_reg;
    assign epoch.payload.epoch_seconds = s5_secs_reg;
    assign epoch.payload.date_accepted = s5_ok_reg;

    // rejected transaction always reports zero seconds
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch.valid && !epoch.payload.date_accepted |-> epoch.payload.epoch_seconds == 32'd0)
        else $error("rejected result with nonzero seconds");

    // a stalled output freezes the whole pipeline
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        epoch.valid && !epoch.ready |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg,
                                                 s4_valid_reg, s5_valid_reg}))
        else $error("pipeline moved during output stall");

    // time of day never exceeds one day including a leap second
    a_hms_range: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && s4_ok_reg |-> s4_hms_reg <= 17'd86400)
        else $error("time of day out of range");

endmodule
